FILE: hdl/e2l_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2l_pkg
// Types, constants and small tables shared by the epoch to local date/time
// converter: transaction payloads, inter-stage records and the reciprocal
// constants used in place of dividers.
// ----------------------------------------------------------------------------
package e2l_pkg;

  // transaction payloads
  typedef struct packed {
    logic [31:0] unix_seconds;
  } in_payload_t;

  typedef struct packed {
    logic signed [15:0] zone_offset_minutes;
  } cfg_payload_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } out_payload_t;

  // time of day carried alongside the date arithmetic
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  // day number split into era and day of era, plus second of day
  typedef struct packed {
    logic [17:0] doe;
    logic        era_hi;
    logic [16:0] sod;
  } split_t;

  // year of era with the remaining day of era and finished time of day
  typedef struct packed {
    logic [8:0]  yoe;
    logic [17:0] doe;
    logic        era_hi;
    tod_t        tod;
  } ydate_t;

  // bias of 24 days keeps the local second count positive for any offset
  localparam logic [21:0] SEC_BIAS       = 22'd2073600;

  // 86400 = 128 * 675: divide the upper bits by 675 with an exact reciprocal
  localparam logic [26:0] DIV675_MUL     = 27'd101806633;
  localparam int unsigned DIV675_SHIFT   = 36;
  localparam logic [9:0]  DIV675         = 10'd675;

  // biased day number at which the day of era wraps into the next era
  localparam logic [15:0] ERA_SPLIT_DAYS = 16'd11041;
  localparam logic [17:0] ERA_LO_ADD     = 18'd135056;

  // day-of-era breakpoints for the century and 400-year corrections
  localparam logic [17:0] DOE_CENT1      = 18'd36524;
  localparam logic [17:0] DOE_CENT2      = 18'd73048;
  localparam logic [17:0] DOE_CENT3      = 18'd109572;
  localparam logic [17:0] DOE_LAST       = 18'd146096;

  // exact reciprocals, valid over the value ranges seen here
  localparam logic [17:0] DIV1460_MUL    = 18'd183861;
  localparam int unsigned DIV1460_SHIFT  = 28;
  localparam logic [17:0] DIV365_MUL     = 18'd183860;
  localparam int unsigned DIV365_SHIFT   = 26;
  localparam logic [12:0] DIV153_MUL     = 13'd6854;
  localparam int unsigned DIV153_SHIFT   = 20;
  localparam logic [17:0] DIV60S_MUL     = 18'd139811;
  localparam int unsigned DIV60S_SHIFT   = 23;
  localparam logic [10:0] DIV60M_MUL     = 11'd1093;
  localparam int unsigned DIV60M_SHIFT   = 16;

  localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;
  localparam logic [5:0]  SIXTY          = 6'd60;
  localparam logic [8:0]  YOE_CENT1      = 9'd100;
  localparam logic [8:0]  YOE_CENT2      = 9'd200;
  localparam logic [8:0]  YOE_CENT3      = 9'd300;
  localparam logic [3:0]  MP_JANUARY     = 4'd10;
  localparam logic [3:0]  MP_MON_ADD     = 4'd3;
  localparam logic [3:0]  MP_MON_SUB     = 4'd9;
  localparam logic [11:0] YEAR_BASE_LO   = 12'd1600;
  localparam logic [11:0] YEAR_BASE_HI   = 12'd2000;

  // first day of each March-based month within the year
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] first;
    unique case (mp)
      4'd0:    first = 9'd0;
      4'd1:    first = 9'd31;
      4'd2:    first = 9'd61;
      4'd3:    first = 9'd92;
      4'd4:    first = 9'd122;
      4'd5:    first = 9'd153;
      4'd6:    first = 9'd184;
      4'd7:    first = 9'd214;
      4'd8:    first = 9'd245;
      4'd9:    first = 9'd275;
      4'd10:   first = 9'd306;
      4'd11:   first = 9'd337;
      default: first = 9'd0;
    endcase
    return first;
  endfunction

endpackage

FILE: hdl/e2l_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2l_chan_if
// Valid/ready channel carrying one payload record per transaction.
// ----------------------------------------------------------------------------
interface e2l_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/e2l_day_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2l_day_split
// Three stages: apply the zone offset, floor-divide the local seconds by
// 86400, then form the second of day and the era / day of era.
// ----------------------------------------------------------------------------
module e2l_day_split (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        unix_seconds_i,
  input  logic signed [15:0] zone_offset_minutes_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output e2l_pkg::split_t    split_o
);
  import e2l_pkg::*;

  logic [2:0]  valid_q;
  logic [3:0]  adv;
  logic [33:0] ofs_ext;
  logic [33:0] ofs_sec;
  logic [33:0] biased_sum;
  logic [32:0] biased_d;
  logic [32:0] biased_q;
  logic [52:0] quot_prod;
  logic [15:0] days_d;
  logic [15:0] days_q;
  logic [25:0] hi_q;
  logic [6:0]  lo_q;
  logic [25:0] days_x675;
  logic [25:0] rem_full;
  split_t      split_d;
  split_t      split_q;

  // stage advance, back from the output
  assign adv[3] = out_ready_i;
  assign adv[2] = !valid_q[2] || adv[3];
  assign adv[1] = !valid_q[1] || adv[2];
  assign adv[0] = !valid_q[0] || adv[1];

  // offset times 60 as shifts, plus bias to keep the count positive
  always_comb begin
    ofs_ext    = {{18{zone_offset_minutes_i[15]}}, zone_offset_minutes_i};
    ofs_sec    = (ofs_ext << 6) - (ofs_ext << 2);
    biased_sum = {2'b00, unix_seconds_i} + ofs_sec + {12'd0, SEC_BIAS};
    biased_d   = biased_sum[32:0];
  end

  // day number from the upper bits by exact reciprocal of 675
  always_comb begin
    quot_prod = {27'd0, biased_q[32:7]} * {26'd0, DIV675_MUL};
    days_d    = quot_prod[DIV675_SHIFT +: 16];
  end

  // remainder gives second of day; era chosen by one compare
  always_comb begin
    days_x675       = {10'd0, days_q} * {16'd0, DIV675};
    rem_full        = hi_q - days_x675;
    split_d.sod     = {rem_full[9:0], lo_q};
    split_d.era_hi  = (days_q >= ERA_SPLIT_DAYS);
    if (split_d.era_hi) begin
      split_d.doe = {2'b00, days_q} - {2'b00, ERA_SPLIT_DAYS};
    end else begin
      split_d.doe = {2'b00, days_q} + ERA_LO_ADD;
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) valid_q[0] <= in_valid_i;
      if (adv[1]) valid_q[1] <= valid_q[0];
      if (adv[2]) valid_q[2] <= valid_q[1];
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    if (adv[0] && in_valid_i) begin
      biased_q <= biased_d;
    end
    if (adv[1] && valid_q[0]) begin
      days_q <= days_d;
      hi_q   <= biased_q[32:7];
      lo_q   <= biased_q[6:0];
    end
    if (adv[2] && valid_q[1]) begin
      split_q <= split_d;
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = valid_q[2];
  assign split_o     = split_q;

endmodule

FILE: hdl/e2l_year_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2l_year_split
// Three stages: leap corrections and year of era from the day of era, and
// hour, minute and second from the second of day in parallel.
// ----------------------------------------------------------------------------
module e2l_year_split (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  e2l_pkg::split_t  split_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output e2l_pkg::ydate_t  ydate_o
);
  import e2l_pkg::*;

  logic [2:0]  valid_q;
  logic [3:0]  adv;

  logic [35:0] cyc_prod;
  logic [34:0] min_prod;
  logic [2:0]  cent_cnt;
  logic [2:0]  bc_d;
  logic [17:0] doe1_q;
  logic        era1_q;
  logic [6:0]  a1_q;
  logic [2:0]  bc1_q;
  logic [16:0] sod1_q;
  logic [10:0] mins1_q;

  logic [17:0] t_d;
  logic [16:0] sec_full;
  logic [21:0] hour_prod;
  logic [17:0] t2_q;
  logic [17:0] doe2_q;
  logic        era2_q;
  logic [10:0] mins2_q;
  logic [4:0]  hour2_q;
  logic [5:0]  sec2_q;

  logic [35:0] yoe_prod;
  logic [10:0] minute_full;
  ydate_t      ydate_d;
  ydate_t      ydate_q;

  // stage advance, back from the output
  assign adv[3] = out_ready_i;
  assign adv[2] = !valid_q[2] || adv[3];
  assign adv[1] = !valid_q[1] || adv[2];
  assign adv[0] = !valid_q[0] || adv[1];

  // day of era over 1460, century count, and minutes of day
  always_comb begin
    cyc_prod = {18'd0, split_i.doe} * {18'd0, DIV1460_MUL};
    cent_cnt = {2'b00, split_i.doe >= DOE_CENT1} + {2'b00, split_i.doe >= DOE_CENT2}
             + {2'b00, split_i.doe >= DOE_CENT3} + {2'b00, split_i.doe >= DOE_LAST};
    bc_d     = cent_cnt - {2'b00, split_i.doe == DOE_LAST};
    min_prod = {18'd0, split_i.sod} * {17'd0, DIV60S_MUL};
  end

  // corrected day count, second and hour
  always_comb begin
    t_d       = doe1_q - {11'd0, a1_q} + {15'd0, bc1_q};
    sec_full  = sod1_q - {6'd0, mins1_q} * {11'd0, SIXTY};
    hour_prod = {11'd0, mins1_q} * {11'd0, DIV60M_MUL};
  end

  // year of era and minute
  always_comb begin
    yoe_prod            = {18'd0, t2_q} * {18'd0, DIV365_MUL};
    minute_full         = mins2_q - {6'd0, hour2_q} * {5'd0, SIXTY};
    ydate_d.yoe         = yoe_prod[DIV365_SHIFT +: 9];
    ydate_d.doe         = doe2_q;
    ydate_d.era_hi      = era2_q;
    ydate_d.tod.hour    = hour2_q;
    ydate_d.tod.minute  = minute_full[5:0];
    ydate_d.tod.second  = sec2_q;
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) valid_q[0] <= in_valid_i;
      if (adv[1]) valid_q[1] <= valid_q[0];
      if (adv[2]) valid_q[2] <= valid_q[1];
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    if (adv[0] && in_valid_i) begin
      doe1_q  <= split_i.doe;
      era1_q  <= split_i.era_hi;
      a1_q    <= cyc_prod[DIV1460_SHIFT +: 7];
      bc1_q   <= bc_d;
      sod1_q  <= split_i.sod;
      mins1_q <= min_prod[DIV60S_SHIFT +: 11];
    end
    if (adv[1] && valid_q[0]) begin
      t2_q    <= t_d;
      doe2_q  <= doe1_q;
      era2_q  <= era1_q;
      mins2_q <= mins1_q;
      hour2_q <= hour_prod[DIV60M_SHIFT +: 5];
      sec2_q  <= sec_full[5:0];
    end
    if (adv[2] && valid_q[1]) begin
      ydate_q <= ydate_d;
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = valid_q[2];
  assign ydate_o     = ydate_q;

endmodule

FILE: hdl/e2l_month_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2l_month_split
// Three stages: day of year, March-based month, then calendar month, day
// and year into the output register.
// ----------------------------------------------------------------------------
module e2l_month_split (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  e2l_pkg::ydate_t       ydate_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output e2l_pkg::out_payload_t result_o
);
  import e2l_pkg::*;

  logic [2:0]   valid_q;
  logic [3:0]   adv;

  logic [1:0]   yoe_cent;
  logic [17:0]  year_days;
  logic [17:0]  doy_full;
  logic [8:0]   doy1_q;
  logic [8:0]   yoe1_q;
  logic         era1_q;
  tod_t         tod1_q;

  logic [10:0]  mp_num;
  logic [23:0]  mp_prod;
  logic [3:0]   mp2_q;
  logic [8:0]   doy2_q;
  logic [8:0]   yoe2_q;
  logic         era2_q;
  tod_t         tod2_q;

  logic [8:0]   dom_full;
  logic         early_year;
  out_payload_t result_d;
  out_payload_t result_q;

  // stage advance, back from the output
  assign adv[3] = out_ready_i;
  assign adv[2] = !valid_q[2] || adv[3];
  assign adv[1] = !valid_q[1] || adv[2];
  assign adv[0] = !valid_q[0] || adv[1];

  // day of year within the March-based year
  always_comb begin
    yoe_cent  = {1'b0, ydate_i.yoe >= YOE_CENT1} + {1'b0, ydate_i.yoe >= YOE_CENT2}
              + {1'b0, ydate_i.yoe >= YOE_CENT3};
    year_days = {9'd0, ydate_i.yoe} * {9'd0, DAYS_PER_YEAR}
              + {11'd0, ydate_i.yoe[8:2]} - {16'd0, yoe_cent};
    doy_full  = ydate_i.doe - year_days;
  end

  // March-based month from (5 * doy + 2) / 153
  always_comb begin
    mp_num  = {doy1_q, 2'b00} + {2'b00, doy1_q} + 11'd2;
    mp_prod = {13'd0, mp_num} * {11'd0, DIV153_MUL};
  end

  // calendar fields; January and February belong to the next year
  always_comb begin
    early_year = (mp2_q >= MP_JANUARY);
    dom_full   = doy2_q - month_start(mp2_q) + 9'd1;
    result_d.day_of_month = dom_full[4:0];
    if (early_year) begin
      result_d.month = mp2_q - MP_MON_SUB;
    end else begin
      result_d.month = mp2_q + MP_MON_ADD;
    end
    result_d.year   = {3'd0, yoe2_q} + (era2_q ? YEAR_BASE_HI : YEAR_BASE_LO)
                    + {11'd0, early_year};
    result_d.hour   = tod2_q.hour;
    result_d.minute = tod2_q.minute;
    result_d.second = tod2_q.second;
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) valid_q[0] <= in_valid_i;
      if (adv[1]) valid_q[1] <= valid_q[0];
      if (adv[2]) valid_q[2] <= valid_q[1];
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    if (adv[0] && in_valid_i) begin
      doy1_q <= doy_full[8:0];
      yoe1_q <= ydate_i.yoe;
      era1_q <= ydate_i.era_hi;
      tod1_q <= ydate_i.tod;
    end
    if (adv[1] && valid_q[0]) begin
      mp2_q  <= mp_prod[DIV153_SHIFT +: 4];
      doy2_q <= doy1_q;
      yoe2_q <= yoe1_q;
      era2_q <= era1_q;
      tod2_q <= tod1_q;
    end
    if (adv[2] && valid_q[1]) begin
      result_q <= result_d;
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = valid_q[2];
  assign result_o    = result_q;

endmodule

FILE: hdl/epoch_to_local_datetime.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_to_local_datetime
// Unix time in seconds to local Gregorian date and 24-hour time of day.
// ----------------------------------------------------------------------------
// A nine-stage pipeline that takes one transaction per clock as long as the
// output is taken without stalls. No stage chains more than one multiply,
// the divisions by 86400, 1460, 365, 153 and 60 being exact reciprocal
// multiplies, and each stage has its own valid bit, so a stalled output
// holds only the stages that are full and input keeps flowing into any
// empty stage. The zone offset in minutes is a register written through
// the configuration channel, which is always ready; write it only while
// no transaction is in flight.
module epoch_to_local_datetime (
  input  logic       clk_i,
  input  logic       rst_ni,
  e2l_chan_if.sink   cfg_i,
  e2l_chan_if.sink   in_i,
  e2l_chan_if.source out_o
);
  import e2l_pkg::*;

  logic signed [15:0] offset_q;
  logic               split_valid;
  logic               split_ready;
  split_t             split;
  logic               ydate_valid;
  logic               ydate_ready;
  ydate_t             ydate;
  out_payload_t       result;

  // zone offset register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      offset_q <= cfg_i.payload.zone_offset_minutes;
    end
  end

  // local seconds to day of era and second of day
  e2l_day_split u_day_split (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_i.valid),
    .in_ready_o            (in_i.ready),
    .unix_seconds_i        (in_i.payload.unix_seconds),
    .zone_offset_minutes_i (offset_q),
    .out_valid_o           (split_valid),
    .out_ready_i           (split_ready),
    .split_o               (split)
  );

  // year of era and time of day
  e2l_year_split u_year_split (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (split_valid),
    .in_ready_o  (split_ready),
    .split_i     (split),
    .out_valid_o (ydate_valid),
    .out_ready_i (ydate_ready),
    .ydate_o     (ydate)
  );

  // month, day and calendar year into the output register
  e2l_month_split u_month_split (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ydate_valid),
    .in_ready_o  (ydate_ready),
    .ydate_i     (ydate),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .result_o    (result)
  );

  assign out_o.payload = result;

`ifndef ASSERT_OFF
  // input is held back only by a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input stalled while the output is free");

  // calendar fields stay in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.payload.month >= 4'd1 && out_o.payload.month <= 4'd12
                     && out_o.payload.day_of_month >= 5'd1))
    else $error("month or day out of range");

  // February never runs past the 29th
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.payload.month == 4'd2) |-> out_o.payload.day_of_month <= 5'd29)
    else $error("day beyond end of February");

  // time of day stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.payload.hour <= 5'd23 && out_o.payload.minute <= 6'd59
                     && out_o.payload.second <= 6'd59))
    else $error("time of day out of range");

  // year stays within what any offset can reach
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.payload.year >= 12'd1969 && out_o.payload.year <= 12'd2106))
    else $error("year out of range");
`endif

endmodule

FILE: sim/tb_epoch_to_local_datetime.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epoch_to_local_datetime
// Self-checking bench for the Unix time to local date/time converter: a
// behavioural model predicts every result from the stamp and the zone
// offset, and a monitor compares each output transaction in order, field by
// field, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_epoch_to_local_datetime;
  import e2l_pkg::*;

  localparam int PIPE_LATENCY = 9;
  localparam int IDLE_PERCENT = 22;
  localparam int STALL_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 180;

  logic clk_i;
  logic rst_ni;

  e2l_chan_if #(.payload_t(cfg_payload_t)) cfg_if ();
  e2l_chan_if #(.payload_t(in_payload_t))  in_if ();
  e2l_chan_if #(.payload_t(out_payload_t)) out_if ();

  epoch_to_local_datetime DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // bench copy of the zone register and expected local date/times
  logic signed [15:0] zone_minutes;
  out_payload_t       pending_datetimes[$];
  int                 error_count;
  int                 idle_cycles;
  bit                 no_gaps;

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // local civil date and time of a UTC stamp under a zone offset
  function automatic out_payload_t civil_local(input logic [31:0] stamp,
                                               input logic signed [15:0] zm);
    longint secs, days, sod, z, era, doe, yoe, doy, mp, dom, mon, yr;
    out_payload_t r;
    secs = longint'(stamp) + longint'(zm) * 60;
    days = secs / 86400;
    sod  = secs % 86400;
    // floor division for local times before the epoch
    if (sod < 0) begin
      sod  = sod + 86400;
      days = days - 1;
    end
    z   = days + 719468;
    era = z / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    dom = doy - (153 * mp + 2) / 5 + 1;
    mon = (mp < 10) ? mp + 3 : mp - 9;
    yr  = yoe + era * 400 + ((mon <= 2) ? 1 : 0);
    r.year         = yr[11:0];
    r.month        = mon[3:0];
    r.day_of_month = dom[4:0];
    r.hour         = 5'(sod / 3600);
    r.minute       = 6'((sod / 60) % 60);
    r.second       = 6'(sod % 60);
    return r;
  endfunction

  // sink side: random back-pressure
  always @(negedge clk_i) begin
    out_if.ready <= no_gaps || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // result monitor
  always @(posedge clk_i) begin
    out_payload_t want;
    out_payload_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      if (pending_datetimes.size() == 0) begin
        $error("unexpected result transaction: %p", got);
        error_count++;
      end else begin
        want = pending_datetimes.pop_front();
        if (got.year !== want.year) begin
          $error("year: expected %0d, actual %0d", want.year, got.year);
          error_count++;
        end
        if (got.month !== want.month) begin
          $error("month: expected %0d, actual %0d", want.month, got.month);
          error_count++;
        end
        if (got.day_of_month !== want.day_of_month) begin
          $error("day_of_month: expected %0d, actual %0d", want.day_of_month,
                 got.day_of_month);
          error_count++;
        end
        if (got.hour !== want.hour) begin
          $error("hour: expected %0d, actual %0d", want.hour, got.hour);
          error_count++;
        end
        if (got.minute !== want.minute) begin
          $error("minute: expected %0d, actual %0d", want.minute, got.minute);
          error_count++;
        end
        if (got.second !== want.second) begin
          $error("second: expected %0d, actual %0d", want.second, got.second);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // one stamp transaction, entered and left at a falling edge
  task automatic send_stamp(input logic [31:0] stamp);
    while (!no_gaps && ($urandom_range(99) < IDLE_PERCENT)) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid                <= 1'b1;
    in_if.payload.unix_seconds <= stamp;
    do @(posedge clk_i); while (!in_if.ready);
    pending_datetimes.push_back(civil_local(stamp, zone_minutes));
    @(negedge clk_i);
  endtask

  // let the pipeline empty out
  task automatic drain;
    in_if.valid <= 1'b0;
    while (pending_datetimes.size() != 0) @(negedge clk_i);
    repeat (PIPE_LATENCY + 3) @(negedge clk_i);
  endtask

  // zone register write, only with the pipeline empty
  task automatic write_zone(input logic signed [15:0] zm);
    drain();
    cfg_if.valid                       <= 1'b1;
    cfg_if.payload.zone_offset_minutes <= zm;
    do @(posedge clk_i); while (!cfg_if.ready);
    zone_minutes = zm;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // stamp for random testing: mostly any value, some near local midnight
  function automatic logic [31:0] random_stamp();
    longint near;
    if ($urandom_range(99) < 70) begin
      return $urandom();
    end
    near = longint'($urandom_range(49710)) * 86400 - longint'(zone_minutes) * 60
           + longint'($urandom_range(20)) - 10;
    return near[31:0];
  endfunction

  // calendar edges under the reset offset of zero
  task automatic test_calendar_edges;
    send_stamp(32'd0);
    send_stamp(32'd1);
    send_stamp(32'd86399);
    send_stamp(32'd86400);
    send_stamp(32'd946684799);
    send_stamp(32'd946684800);
    send_stamp(32'd951782400);
    send_stamp(32'd951868799);
    send_stamp(32'd4107542399);
    send_stamp(32'd4107542400);
    send_stamp(32'h7FFF_FFFF);
    send_stamp(32'h8000_0000);
    send_stamp(32'hFFFF_FFFF);
  endtask

  // offset extremes, times before 1970 and alternating offset bits
  task automatic test_extreme_offsets;
    write_zone(16'sh8000);
    send_stamp(32'd0);
    send_stamp(32'd86399);
    send_stamp(32'hFFFF_FFFF);
    write_zone(16'sh7FFF);
    send_stamp(32'd0);
    send_stamp(32'hFFFF_FFFF);
    write_zone(-16'sd1);
    send_stamp(32'd0);
    send_stamp(32'd59);
    write_zone(16'shAAAA);
    send_stamp(32'h5555_5555);
    write_zone(16'sh5555);
    send_stamp(32'hAAAA_AAAA);
  endtask

  // random stamps over a series of zone settings
  task automatic test_random_zones;
    logic signed [15:0] zones[8];
    zones[0] = 16'($urandom_range(65535));
    zones[1] = 16'sh8000;
    zones[2] = 16'sh7FFF;
    zones[3] = 16'sd0;
    zones[4] = 16'($urandom_range(65535));
    zones[5] = -16'sd1;
    zones[6] = 16'($signed(11'($urandom_range(2047))));
    zones[7] = 16'($urandom_range(65535));
    foreach (zones[i]) begin
      write_zone(zones[i]);
      repeat (PHASE_ITEMS) send_stamp(random_stamp());
    end
  endtask

  // full-rate stretch with neither side idling
  task automatic test_back_to_back;
    write_zone(16'($urandom_range(65535)));
    no_gaps = 1'b1;
    repeat (200) send_stamp(random_stamp());
    no_gaps = 1'b0;
  endtask

  // sequence
  initial begin
    rst_ni                             = 1'b0;
    cfg_if.valid                       = 1'b0;
    cfg_if.payload.zone_offset_minutes = '0;
    in_if.valid                        = 1'b0;
    in_if.payload.unix_seconds         = '0;
    out_if.ready                       = 1'b0;
    zone_minutes                       = '0;
    error_count                        = 0;
    idle_cycles                        = 0;
    no_gaps                            = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_calendar_edges();
    test_extreme_offsets();
    test_random_zones();
    test_back_to_back();

    drain();
    repeat (PIPE_LATENCY * 2) @(negedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
